/* rtl/clib_pkg.sv */
`default_nettype none

package clib_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int LINE_DEPTH_DEF = 256;

    localparam logic [1:0] MODE_RX    = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_CHAR  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_EOF   = 2'd2;
    localparam logic [1:0] ST_AVAIL = 2'd3;

    localparam logic [1:0] SIG_IDLE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    localparam logic [7:0] CH_INTR = 8'd3;
    localparam logic [7:0] CH_EOT  = 8'd4;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_SUSP = 8'd26;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_DEL  = 8'd127;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_char;
        logic       available;
    } out_item_t;

    function automatic logic is_term(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR) || (b == CH_EOT);
    endfunction

endpackage

`default_nettype wire

/* rtl/canonical_line_input_buffer_core.sv */
// a read or query result goes through the s1, s2 and result registers
// throughput: one beat per cycle unless the output stalls; a line-mode read
// popping a ring byte holds the input while the byte is in the line rules
// reset: rst_n clears pointers, counts, flags and raw mode at once; the ring
// and line memories are not cleared and need no clearing pass
`default_nettype none

module canonical_line_input_buffer_core #(
    parameter int RING_DEPTH = clib_pkg::RING_DEPTH_DEF,
    parameter int LINE_DEPTH = clib_pkg::LINE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_stall,
    input  clib_pkg::in_item_t  item,
    output logic                result_valid,
    input  wire                 result_stall,
    output clib_pkg::out_item_t result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data
);

    import clib_pkg::*;

    localparam int RA_W = $clog2(RING_DEPTH);
    localparam int RC_W = $clog2(RING_DEPTH + 1);
    localparam int LA_W = $clog2(LINE_DEPTH);
    localparam int LC_W = $clog2(LINE_DEPTH + 1);

    typedef enum logic [3:0] {
        K_FIXED = 4'b0001,
        K_RAW   = 4'b0010,
        K_DRAIN = 4'b0100,
        K_LINE  = 4'b1000
    } kind_t;

    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] line_mem [LINE_DEPTH];
    logic [7:0] ring_rd_reg;
    logic [7:0] line_rd_reg;

    logic [RA_W-1:0] head_reg, head_next;
    logic [RA_W-1:0] tail_reg, tail_next;
    logic [RC_W-1:0] count_reg, count_next;
    logic [RC_W-1:0] term_reg, term_next;
    logic [1:0]      pending_reg, pending_next;
    logic [LC_W-1:0] len_reg, len_next;
    logic [LC_W-1:0] drain_reg, drain_next;
    logic            ready_reg, ready_next;
    logic            raw_reg;

    logic            s1_valid_reg;
    kind_t           s1_kind_reg, s1_kind_next;
    out_item_t       s1_res_reg, s1_res_next;
    logic            s2_valid_reg;
    out_item_t       s2_res_reg, s2_res_next;
    logic            s2_from_line_reg, s2_from_line_next;
    logic            result_valid_reg;
    out_item_t       result_reg;

    logic            adv;
    logic            line_busy;
    logic            accept;
    logic            s1_load;
    logic            ring_we;
    logic            ring_re;
    logic            line_we;
    logic            line_re;
    logic [LA_W-1:0] line_raddr;
    logic            term_inc;
    logic            term_dec;
    logic            draining;
    logic [LC_W-1:0] drain_inc;
    logic [7:0]      r;
    logic [LC_W-1:0] lr_len;
    logic            lr_complete;
    logic [1:0]      lr_status;

    assign adv          = !result_valid_reg || !result_stall;
    assign line_busy    = s1_valid_reg && (s1_kind_reg == K_LINE);
    assign item_stall   = !adv || line_busy;
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign r            = ring_rd_reg;
    assign draining     = ready_reg && (drain_reg < len_reg);
    assign drain_inc    = drain_reg + LC_W'(1);

    // line rules on the popped byte
    always_comb
    begin
        lr_len      = len_reg;
        lr_complete = 1'b0;
        lr_status   = ST_NONE;
        line_we     = 1'b0;
        case (r)
            CH_BS, CH_DEL:
            begin
                if (len_reg != '0)
                begin
                    lr_len = len_reg - LC_W'(1);
                end
            end
            CH_LF, CH_CR:
            begin
                if (len_reg < LC_W'(LINE_DEPTH))
                begin
                    line_we = 1'b1;
                    lr_len  = len_reg + LC_W'(1);
                end
                lr_complete = 1'b1;
            end
            CH_EOT:
            begin
                if (len_reg == '0)
                begin
                    lr_status = ST_EOF;
                end
                else
                begin
                    lr_complete = 1'b1;
                end
            end
            CH_ESC:
            begin
                lr_len = len_reg;
            end
            default:
            begin
                if (len_reg < LC_W'(LINE_DEPTH))
                begin
                    line_we = 1'b1;
                    lr_len  = len_reg + LC_W'(1);
                end
            end
        endcase
        if (!(adv && line_busy))
        begin
            line_we = 1'b0;
        end
    end

    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        pending_next      = pending_reg;
        len_next          = len_reg;
        drain_next        = drain_reg;
        ready_next        = ready_reg;
        s1_load           = 1'b0;
        s1_kind_next      = K_FIXED;
        s1_res_next       = '{status: ST_NONE, out_char: 8'd0, available: 1'b0};
        ring_we           = 1'b0;
        ring_re           = 1'b0;
        line_re           = 1'b0;
        line_raddr        = drain_reg[LA_W-1:0];
        s2_res_next       = s1_res_reg;
        s2_from_line_next = 1'b0;

        if (accept)
        begin
            case (item.mode)
                MODE_RX:
                begin
                    if (!raw_reg && item.rx_byte == CH_INTR)
                    begin
                        pending_next = SIG_INTR;
                    end
                    else if (!raw_reg && item.rx_byte == CH_SUSP)
                    begin
                        pending_next = SIG_SUSP;
                    end
                    else if (count_reg < RC_W'(RING_DEPTH))
                    begin
                        ring_we    = 1'b1;
                        count_next = count_reg + RC_W'(1);
                        tail_next  = (tail_reg == RA_W'(RING_DEPTH - 1)) ? '0
                                                                         : tail_reg + RA_W'(1);
                    end
                end
                MODE_QUERY:
                begin
                    s1_load               = 1'b1;
                    s1_res_next.status    = ST_AVAIL;
                    s1_res_next.available = raw_reg ? (count_reg != '0)
                                                    : (draining || term_reg != '0);
                end
                MODE_READ:
                begin
                    s1_load = 1'b1;
                    if (pending_reg != SIG_IDLE)
                    begin
                        s1_res_next.status   = ST_CHAR;
                        s1_res_next.out_char = (pending_reg == SIG_INTR) ? CH_INTR : CH_SUSP;
                        pending_next         = SIG_IDLE;
                    end
                    else if (raw_reg || !draining)
                    begin
                        if (count_reg != '0)
                        begin
                            ring_re      = 1'b1;
                            s1_kind_next = raw_reg ? K_RAW : K_LINE;
                            count_next   = count_reg - RC_W'(1);
                            head_next    = (head_reg == RA_W'(RING_DEPTH - 1)) ? '0
                                                                               : head_reg + RA_W'(1);
                        end
                    end
                    else
                    begin
                        line_re      = 1'b1;
                        s1_kind_next = K_DRAIN;
                        if (drain_inc >= len_reg)
                        begin
                            len_next   = '0;
                            drain_next = '0;
                            ready_next = 1'b0;
                        end
                        else
                        begin
                            drain_next = drain_inc;
                        end
                    end
                end
                default:
                begin
                    s1_load = 1'b0;
                end
            endcase
        end

        case (s1_kind_reg)
            K_RAW:
            begin
                s2_res_next = '{status: ST_CHAR, out_char: ring_rd_reg, available: 1'b0};
            end
            K_DRAIN:
            begin
                s2_res_next = '{status: ST_CHAR, out_char: line_rd_reg, available: 1'b0};
            end
            K_LINE:
            begin
                s2_res_next = '{status: lr_status, out_char: 8'd0, available: 1'b0};
                if (adv)
                begin
                    len_next = lr_len;
                end
                if (lr_complete)
                begin
                    s2_res_next.status = ST_CHAR;
                    line_raddr         = '0;
                    line_re            = adv;
                    if (len_reg == '0)
                    begin
                        s2_res_next.out_char = r;
                    end
                    else
                    begin
                        s2_from_line_next = 1'b1;
                    end
                    if (adv)
                    begin
                        if (lr_len <= LC_W'(1))
                        begin
                            len_next   = '0;
                            drain_next = '0;
                            ready_next = 1'b0;
                        end
                        else
                        begin
                            drain_next = LC_W'(1);
                            ready_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                s2_res_next = s1_res_reg;
            end
        endcase
    end

    assign term_inc = ring_we && is_term(item.rx_byte);
    assign term_dec = adv && s1_valid_reg && (s1_kind_reg == K_RAW || s1_kind_reg == K_LINE)
                      && is_term(ring_rd_reg) && (term_reg != '0);

    always_comb
    begin
        term_next = term_reg;
        if (term_inc && !term_dec)
        begin
            term_next = term_reg + RC_W'(1);
        end
        else if (!term_inc && term_dec)
        begin
            term_next = term_reg - RC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[tail_reg] <= item.rx_byte;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[len_reg[LA_W-1:0]] <= r;
        end
        if (line_re)
        begin
            line_rd_reg <= line_mem[line_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            term_reg         <= '0;
            pending_reg      <= SIG_IDLE;
            len_reg          <= '0;
            drain_reg        <= '0;
            ready_reg        <= 1'b0;
            raw_reg          <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_kind_reg      <= K_FIXED;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            term_reg    <= term_next;
            pending_reg <= pending_next;
            len_reg     <= len_next;
            drain_reg   <= drain_next;
            ready_reg   <= ready_next;
            if (cfg_valid && cfg_ready)
            begin
                raw_reg <= cfg_data;
            end
            if (adv)
            begin
                s1_valid_reg     <= s1_load;
                s1_kind_reg      <= s1_kind_next;
                s2_valid_reg     <= s1_valid_reg;
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_res_reg       <= s1_res_next;
            s2_res_reg       <= s2_res_next;
            s2_from_line_reg <= s2_from_line_next;
            result_reg       <= s2_from_line_reg
                                ? out_item_t'{status: s2_res_reg.status,
                                              out_char: line_rd_reg,
                                              available: s2_res_reg.available}
                                : s2_res_reg;
        end
    end

`ifndef SYNTHESIS
    a_line_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        line_busy |-> item_stall)
        else $error("beat accepted while a popped byte is in the line rules");

    a_term_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        (term_reg <= count_reg)
        || (s1_valid_reg && (s1_kind_reg == K_RAW || s1_kind_reg == K_LINE)))
        else $error("terminator count exceeds ring fill");

    a_ready_draining: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (drain_reg < len_reg))
        else $error("completed line has no byte left to drain");

    a_drain_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg != '0) |-> ready_reg)
        else $error("drain position moved without a completed line");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (s2_valid_reg == $past(s2_valid_reg)))
        else $error("pipeline advanced under output stall");
`endif

endmodule

`default_nettype wire

/* sim/tty_reply_checker.sv */
module tty_reply_checker
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    input  wire                 item_stall,
    input  clib_pkg::in_item_t  item,
    input  wire                 result_valid,
    input  wire                 result_stall,
    input  clib_pkg::out_item_t result,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  wire                 cfg_data,
    output int                  mismatches,
    output int                  replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import clib_pkg::*;

    localparam int RING_SIZE = RING_DEPTH_DEF;
    localparam int LINE_SIZE = LINE_DEPTH_DEF;

    typedef enum logic [1:0] {EDIT_OPEN, EDIT_DONE, EDIT_EOF} edit_outcome_t;

    logic [7:0] ring_mem [RING_SIZE];
    logic [7:0] line_mem [LINE_SIZE];
    logic [7:0] ring_rd;
    logic [8:0] ring_fill;
    logic [8:0] term_fill;
    logic [8:0] line_len;
    logic [8:0] drain_at;
    logic [1:0] sig_pending;
    logic       line_done;
    logic       eof_seen;
    logic       raw;

    out_item_t replies_due [$];
    int error_count = 0;

    function automatic logic ends_line(input logic [7:0] b);
        return b == CH_LF || b == CH_CR || b == CH_EOT;
    endfunction

    function automatic void ring_put(input logic [7:0] b);
        if (ring_fill < RING_SIZE)
        begin
            ring_mem[(int'(ring_rd) + int'(ring_fill)) % RING_SIZE] = b;
            ring_fill++;
            if (ends_line(b))
                term_fill++;
        end
    endfunction

    function automatic logic [7:0] ring_take();
        logic [7:0] b;
        b = ring_mem[ring_rd];
        ring_rd = 8'((int'(ring_rd) + 1) % RING_SIZE);
        ring_fill--;
        if (ends_line(b) && term_fill != 0)
            term_fill--;
        return b;
    endfunction

    function automatic logic [7:0] line_next();
        logic [7:0] c;
        c = line_mem[int'(drain_at) % LINE_SIZE];
        drain_at++;
        if (drain_at >= line_len)
        begin
            line_len = 0;
            drain_at = 0;
            line_done = 1'b0;
        end
        return c;
    endfunction

    function automatic edit_outcome_t edit_line(input logic [7:0] b);
        if (b == CH_BS || b == CH_DEL)
        begin
            if (line_len != 0)
                line_len--;
            return EDIT_OPEN;
        end
        if (b == CH_LF || b == CH_CR)
        begin
            if (line_len < LINE_SIZE)
            begin
                line_mem[int'(line_len)] = b;
                line_len++;
            end
            drain_at = 0;
            return EDIT_DONE;
        end
        if (b == CH_EOT)
        begin
            if (line_len == 0)
            begin
                eof_seen = 1'b1;
                return EDIT_EOF;
            end
            drain_at = 0;
            return EDIT_DONE;
        end
        if (b != CH_ESC && line_len < LINE_SIZE)
        begin
            line_mem[int'(line_len)] = b;
            line_len++;
        end
        return EDIT_OPEN;
    endfunction

    function automatic logic predict_reply(input in_item_t it, output out_item_t reply);
        edit_outcome_t outcome;
        reply = '{status: ST_NONE, out_char: 8'd0, available: 1'b0};
        case (it.mode)
            MODE_RX:
            begin
                if (!raw && it.rx_byte == CH_INTR)
                    sig_pending = SIG_INTR;
                else if (!raw && it.rx_byte == CH_SUSP)
                    sig_pending = SIG_SUSP;
                else
                    ring_put(it.rx_byte);
                return 1'b0;
            end
            MODE_QUERY:
            begin
                reply.status = ST_AVAIL;
                if (raw)
                    reply.available = ring_fill != 0;
                else
                    reply.available = (line_done && drain_at < line_len) || term_fill != 0;
            end
            MODE_READ:
            begin
                if (sig_pending == SIG_INTR || sig_pending == SIG_SUSP)
                begin
                    reply.status = ST_CHAR;
                    reply.out_char = (sig_pending == SIG_INTR) ? CH_INTR : CH_SUSP;
                    sig_pending = SIG_IDLE;
                end
                else if (raw)
                begin
                    if (ring_fill != 0)
                    begin
                        reply.status = ST_CHAR;
                        reply.out_char = ring_take();
                    end
                end
                else if (line_done && drain_at < line_len)
                begin
                    reply.status = ST_CHAR;
                    reply.out_char = line_next();
                end
                else if (eof_seen)
                begin
                    eof_seen = 1'b0;
                    reply.status = ST_EOF;
                end
                else if (ring_fill != 0)
                begin
                    outcome = edit_line(ring_take());
                    if (outcome == EDIT_DONE && line_len != 0)
                    begin
                        line_done = 1'b1;
                        reply.status = ST_CHAR;
                        reply.out_char = line_next();
                    end
                    else if (outcome == EDIT_EOF)
                    begin
                        eof_seen = 1'b0;
                        reply.status = ST_EOF;
                    end
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t reply;
        out_item_t due;
        if (!rst_n)
        begin
            ring_rd = '0;
            ring_fill = '0;
            term_fill = '0;
            line_len = '0;
            drain_at = '0;
            sig_pending = SIG_IDLE;
            line_done = 1'b0;
            eof_seen = 1'b0;
            raw = 1'b0;
            replies_due.delete();
            mismatches <= error_count;
            replies_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                raw = cfg_data;
            if (item_valid && !item_stall)
            begin
                if (predict_reply(item, reply))
                    replies_due.push_back(reply);
            end
            if (result_valid && !result_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: expected no beat, got status %0d char %0d available %0d",
                             $time, result.status, result.out_char, result.available);
                    error_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    compare_field("status", due.status, result.status);
                    compare_field("out_char", due.out_char, result.out_char);
                    compare_field("available", due.available, result.available);
                end
            end
            mismatches <= error_count;
            replies_owed <= replies_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clib_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RING_SIZE = RING_DEPTH_DEF;
    localparam int LINE_SIZE = LINE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int LINE_ITEMS = 30;
    localparam int RAW_ITEMS = 12;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    int mismatches;
    int replies_owed;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int beats_sent = 0;

    canonical_line_input_buffer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    tty_reply_checker reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_beat(input logic [1:0] m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{mode: m, rx_byte: b};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (m != MODE_UNUSED)
            beats_sent++;
    endtask

    // hold off until every reply is back and the last received byte has gone through
    task automatic settle();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_raw(input logic v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 68)
            return 8'($urandom_range(126, 32));
        if (pick < 78)
            return CH_BS;
        if (pick < 83)
            return CH_DEL;
        if (pick < 86)
            return CH_ESC;
        if (pick < 90)
            return ($urandom_range(1) == 0) ? CH_INTR : CH_SUSP;
        return 8'($urandom_range(255));
    endfunction

    task automatic directed_checks();
        send_beat(MODE_READ, 8'd0);
        send_beat(MODE_QUERY, 8'd255);
        send_beat(MODE_RX, CH_INTR);
        send_beat(MODE_RX, CH_SUSP);
        send_beat(MODE_READ, 8'd0);
        send_beat(MODE_READ, 8'd0);
        send_beat(MODE_UNUSED, 8'd255);
        send_beat(MODE_RX, 8'd0);
        send_beat(MODE_RX, 8'd255);
        send_beat(MODE_RX, CH_BS);
        send_beat(MODE_RX, CH_DEL);
        send_beat(MODE_RX, CH_ESC);
        send_beat(MODE_RX, CH_LF);
        send_beat(MODE_QUERY, 8'd0);
        // reads pop the edited bytes and give no data until the lf completes the line
        repeat (6) send_beat(MODE_READ, 8'd0);
        send_beat(MODE_RX, CH_EOT);
        send_beat(MODE_READ, 8'd0);
        send_beat(MODE_RX, 8'd120);
        send_beat(MODE_RX, CH_EOT);
        send_beat(MODE_READ, 8'd0);
        send_beat(MODE_READ, 8'd0);
    endtask

    // overfill the ring, then fill the line store so the lf cannot be stored
    task automatic long_line_check();
        repeat (RING_SIZE + 4) send_beat(MODE_RX, 8'($urandom_range(126, 32)));
        send_beat(MODE_QUERY, 8'd0);
        repeat (RING_SIZE) send_beat(MODE_READ, 8'd0);
        send_beat(MODE_RX, CH_LF);
        send_beat(MODE_QUERY, 8'd0);
        repeat (LINE_SIZE + 1) send_beat(MODE_READ, 8'd0);
    endtask

    task automatic type_line();
        int len;
        int reads;
        logic [7:0] ender;
        len = $urandom_range(12);
        repeat (len) send_beat(MODE_RX, text_byte());
        case ($urandom_range(2))
            0: ender = CH_LF;
            1: ender = CH_CR;
            default: ender = CH_EOT;
        endcase
        send_beat(MODE_RX, ender);
        reads = $urandom_range(len + 3, len / 2);
        repeat (reads)
            send_beat(($urandom_range(9) == 0) ? MODE_QUERY : MODE_READ,
                      8'($urandom_range(255)));
    endtask

    task automatic line_segment(input int target);
        int stop;
        stop = beats_sent + target;
        while (beats_sent < stop)
        begin
            case ($urandom_range(19))
                0, 1: send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
                2: settle();
                3, 4:
                    repeat ($urandom_range(4, 1))
                        send_beat(($urandom_range(3) == 0) ? MODE_QUERY : MODE_READ,
                                  8'($urandom_range(255)));
                default: type_line();
            endcase
        end
    endtask

    task automatic raw_segment(input int target);
        int stop;
        stop = beats_sent + target;
        while (beats_sent < stop)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: send_beat(MODE_RX, 8'($urandom_range(255)));
                5, 6, 7: send_beat(MODE_READ, 8'($urandom_range(255)));
                8: send_beat(MODE_QUERY, 8'($urandom_range(255)));
                default: send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
            endcase
        end
    endtask

    initial
    begin
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 11;
        stall_pct <= 67;
        write_raw(1'b0);
        directed_checks();
        long_line_check();
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 11;
                    stall_pct <= 67;
                end
                1:
                begin
                    send_idle_pct <= 67;
                    stall_pct <= 11;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    stall_pct <= 0;
                end
            endcase
            line_segment(LINE_ITEMS);
            // leave a line stored while raw mode runs
            send_beat(MODE_RX, 8'd107);
            send_beat(MODE_RX, CH_LF);
            send_beat(MODE_READ, 8'd0);
            settle();
            write_raw(1'b1);
            raw_segment(RAW_ITEMS);
            settle();
            write_raw(1'b0);
        end
        settle();
        if (mismatches == 0 && replies_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
